>>> hdl/msrp_pkg.sv
package msrp_pkg;

	// channel count and field widths
	localparam int CHANNELS    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EMIT_COUNT  = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
	localparam int OP_W        = 2;
	localparam int CH_W        = 4;
	localparam int DELTA_W     = 13;
	localparam int POS_W       = 12;
	localparam int TICK_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;
	// wide enough for position plus delta, and for any difference of two sums
	localparam int ALU_W       = 15;

	// register values after reset
	localparam logic [POS_W-1:0]  MIN_RESET    = POS_W'(80);
	localparam logic [POS_W-1:0]  MAX_RESET    = POS_W'(510);
	localparam logic [POS_W-1:0]  CENTER_RESET = POS_W'(295);
	localparam logic [TICK_W-1:0] STEP_RESET   = TICK_W'(35);

	typedef enum logic [OP_W-1:0] {
		OP_MOVE  = 2'd0,
		OP_RESET = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN    = 2'd0,
		REG_MAX    = 2'd1,
		REG_CENTER = 2'd2,
		REG_STEP   = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		KIND_UPDATE  = 1'b0,
		KIND_REFUSED = 1'b1
	} kind_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MV_SUM,
		ST_MV_LO,
		ST_MV_HI,
		ST_MV_CMP,
		ST_TK_INC,
		ST_TK_CMP,
		ST_TK_DIR,
		ST_TK_STEP,
		ST_TK_END,
		ST_RST,
		ST_EMIT
	} state_t;

	typedef struct packed {
		alu_op_t                  op;
		logic signed [ALU_W-1:0] a;
		logic signed [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic signed [ALU_W-1:0] res;
		logic                    lt;
		logic                    eq;
	} alu_rsp_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [CH_AW-1:0] addr;
		logic [POS_W-1:0] wdata;
	} pos_req_t;

	typedef struct packed {
		kind_t            kind;
		logic [CH_W-1:0]  ch;
		logic [POS_W-1:0] pw;
		logic             last;
	} result_t;

	// zero extend a position count into the shared unit width
	function automatic logic signed [ALU_W-1:0] zext_pos(input logic [POS_W-1:0] v);
		return ALU_W'($signed({1'b0, v}));
	endfunction

	// zero extend a tick count into the shared unit width
	function automatic logic signed [ALU_W-1:0] zext_tick(input logic [TICK_W-1:0] v);
		return ALU_W'($signed({1'b0, v}));
	endfunction

endpackage

>>> hdl/msrp_ifs.sv
interface msrp_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [msrp_pkg::OP_W-1:0]         opcode;
	logic [msrp_pkg::CH_W-1:0]         channel;
	logic signed [msrp_pkg::DELTA_W-1:0] delta;

	modport source (output valid, output opcode, output channel, output delta, input ready);
	modport sink (input valid, input opcode, input channel, input delta, output ready);
endinterface

interface msrp_res_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [msrp_pkg::CH_W-1:0]  out_channel;
	logic [msrp_pkg::POS_W-1:0] pulse_width;
	logic                       last;

	modport source (output valid, output kind, output out_channel, output pulse_width,
		output last, input ready);
	modport sink (input valid, input kind, input out_channel, input pulse_width,
		input last, output ready);
endinterface

interface msrp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [msrp_pkg::CFG_IDX_W-1:0]  index;
	logic [msrp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/multi_servo_ramp_positioner.sv
// channel  dir  transfer content
// cmd      in   opcode, channel, delta
// res      out  kind, out_channel, pulse_width, last
// cfg      in   index, data (register write, always ready)
//
// a reset sweeps every entry of the position store (16); after each item the
// sequencer returns to idle, where the next cmd transfer is taken.
// every step runs through the one shared adder/comparator in msrp_alu.
// arst_n clears the sequencer, ramp state and registers to their reset counts;
// the position store needs no clearing pass, per-entry valid bits cover it.
// cmd is held off while an item is in work; a stalled res holds the sequencer
// at the result it wants to hand over.
module multi_servo_ramp_positioner (
	input logic       clk,
	input logic       arst_n,
	msrp_cmd_if.sink  cmd,
	msrp_res_if.source res,
	msrp_cfg_if.sink  cfg
);
	import msrp_pkg::*;

	state_t state_q, state_d;

	// configuration registers
	logic [POS_W-1:0]  min_q, max_q, center_q;
	logic [TICK_W-1:0] step_q;
	logic [TICK_W-1:0] limit;

	// latched command
	op_t                      cmd_op_q;
	logic [CH_W-1:0]          cmd_ch_q;
	logic signed [DELTA_W-1:0] cmd_delta_q;

	// working and ramp state
	logic signed [ALU_W-1:0] sum_q;
	logic [POS_W-1:0]        target_q;
	logic                    ramp_active_q;
	logic [CH_W-1:0]         ramp_ch_q;
	logic [POS_W-1:0]        ramp_val_q, ramp_tgt_q;
	logic [TICK_W-1:0]       tick_q;
	logic                    dir_up_q;
	logic [CH_AW-1:0]        idx_q;
	result_t                 pend_q;

	// output register
	logic    out_valid_q;
	result_t out_q, out_d;
	logic    load_out, out_free, rst_step, in_range, rst_emit;

	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	pos_req_t         pos_req;
	logic [POS_W-1:0] pos_rd;

	msrp_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	msrp_pos_mem u_pos_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (pos_req),
		.rd_data (pos_rd)
	);

	assign limit    = (step_q == '0) ? TICK_W'(1) : step_q;
	assign out_free = !out_valid_q || res.ready;
	assign in_range = int'(cmd_ch_q) < CHANNELS;
	assign rst_emit = int'(idx_q) < EMIT_COUNT;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= MIN_RESET;
			max_q    <= MAX_RESET;
			center_q <= CENTER_RESET;
			step_q   <= STEP_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MIN:    min_q    <= cfg.data[POS_W-1:0];
				REG_MAX:    max_q    <= cfg.data[POS_W-1:0];
				REG_CENTER: center_q <= cfg.data[POS_W-1:0];
				REG_STEP:   step_q   <= cfg.data[TICK_W-1:0];
				default:    min_q    <= min_q;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, shared unit operands, store access, result load
	always_comb begin
		state_d  = state_q;
		alu_req  = '{op: ALU_ADD, a: '0, b: '0};
		pos_req  = '0;
		load_out = 1'b0;
		rst_step = 1'b0;
		out_d    = '{kind: KIND_UPDATE, ch: '0, pw: '0, last: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (cmd_op_q)
					OP_MOVE: begin
						if (!in_range) begin
							state_d = ST_IDLE;
						end else if (ramp_active_q) begin
							state_d = ST_EMIT;
						end else begin
							pos_req.rd_en = 1'b1;
							pos_req.addr  = CH_AW'(cmd_ch_q);
							state_d       = ST_MV_SUM;
						end
					end
					OP_RESET: state_d = ST_RST;
					OP_TICK:  state_d = ramp_active_q ? ST_TK_INC : ST_IDLE;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_MV_SUM: begin
				alu_req = '{op: ALU_ADD, a: zext_pos(pos_rd), b: ALU_W'(cmd_delta_q)};
				state_d = ST_MV_LO;
			end
			ST_MV_LO: begin
				alu_req = '{op: ALU_SUB, a: sum_q, b: zext_pos(min_q)};
				state_d = alu_rsp.lt ? ST_MV_CMP : ST_MV_HI;
			end
			ST_MV_HI: begin
				alu_req = '{op: ALU_SUB, a: sum_q, b: zext_pos(max_q)};
				state_d = ST_MV_CMP;
			end
			ST_MV_CMP: begin
				alu_req = '{op: ALU_SUB, a: zext_pos(target_q), b: zext_pos(pos_rd)};
				state_d = alu_rsp.eq ? ST_IDLE : ST_EMIT;
			end
			ST_TK_INC: begin
				alu_req = '{op: ALU_ADD, a: zext_tick(tick_q), b: ALU_W'(1)};
				state_d = ST_TK_CMP;
			end
			ST_TK_CMP: begin
				alu_req = '{op: ALU_SUB, a: zext_tick(tick_q), b: zext_tick(limit)};
				state_d = alu_rsp.lt ? ST_IDLE : ST_TK_DIR;
			end
			ST_TK_DIR: begin
				alu_req = '{op: ALU_SUB, a: zext_pos(ramp_val_q), b: zext_pos(ramp_tgt_q)};
				state_d = ST_TK_STEP;
			end
			ST_TK_STEP: begin
				alu_req = '{op: ALU_ADD, a: zext_pos(ramp_val_q),
					b: dir_up_q ? ALU_W'(1) : {ALU_W{1'b1}}};
				state_d = ST_TK_END;
			end
			ST_TK_END: begin
				alu_req = '{op: ALU_SUB, a: zext_pos(ramp_val_q), b: zext_pos(ramp_tgt_q)};
				if (alu_rsp.eq) begin
					pos_req.wr_en = 1'b1;
					pos_req.addr  = CH_AW'(ramp_ch_q);
					pos_req.wdata = ramp_tgt_q;
				end
				state_d = ST_EMIT;
			end
			ST_RST: begin
				// sweep every entry; hand a result over for the first ones
				pos_req.wr_en = 1'b1;
				pos_req.addr  = idx_q;
				pos_req.wdata = center_q;
				if (!rst_emit || out_free) begin
					rst_step = 1'b1;
					if (rst_emit) begin
						load_out = 1'b1;
						out_d    = '{kind: KIND_UPDATE, ch: CH_W'(idx_q), pw: center_q,
							last: (int'(idx_q) == EMIT_COUNT - 1)};
					end
					if (idx_q == CH_AW'(CHANNELS - 1)) state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					out_d    = pend_q;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ramp control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_active_q <= 1'b0;
			tick_q        <= '0;
		end else begin
			unique case (state_q)
				ST_DECODE: begin
					if (cmd_op_q == OP_RESET) begin
						ramp_active_q <= 1'b0;
						tick_q        <= '0;
					end
				end
				ST_MV_CMP: begin
					if (!alu_rsp.eq) begin
						ramp_active_q <= 1'b1;
						tick_q        <= '0;
					end
				end
				ST_TK_INC: tick_q <= alu_rsp.res[TICK_W-1:0];
				ST_TK_CMP: if (!alu_rsp.lt) tick_q <= '0;
				ST_TK_END: if (alu_rsp.eq) ramp_active_q <= 1'b0;
				default: ramp_active_q <= ramp_active_q;
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_op_q    <= op_t'(cmd.opcode);
			cmd_ch_q    <= cmd.channel;
			cmd_delta_q <= cmd.delta;
		end
		unique case (state_q)
			ST_DECODE: begin
				idx_q  <= '0;
				pend_q <= '{kind: KIND_REFUSED, ch: cmd_ch_q, pw: '0, last: 1'b1};
			end
			ST_MV_SUM: sum_q <= alu_rsp.res;
			ST_MV_LO:  if (alu_rsp.lt) target_q <= min_q;
			ST_MV_HI: begin
				if (!alu_rsp.lt && !alu_rsp.eq) target_q <= max_q;
				else target_q <= sum_q[POS_W-1:0];
			end
			ST_MV_CMP: begin
				ramp_ch_q  <= cmd_ch_q;
				ramp_val_q <= pos_rd;
				ramp_tgt_q <= target_q;
				pend_q     <= '{kind: KIND_UPDATE, ch: cmd_ch_q, pw: pos_rd, last: 1'b1};
			end
			ST_TK_DIR:  dir_up_q   <= alu_rsp.lt;
			ST_TK_STEP: ramp_val_q <= alu_rsp.res[POS_W-1:0];
			ST_TK_END:  pend_q <= '{kind: KIND_UPDATE, ch: ramp_ch_q, pw: ramp_val_q, last: 1'b1};
			ST_RST:     if (rst_step) idx_q <= idx_q + CH_AW'(1);
			default:    sum_q <= sum_q;
		endcase
	end

	// output register, refilled while the previous result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) out_q <= out_d;
	end

	assign res.valid       = out_valid_q;
	assign res.kind        = out_q.kind;
	assign res.out_channel = out_q.ch;
	assign res.pulse_width = out_q.pw;
	assign res.last        = out_q.last;

	// an active ramp is never already at its target between items
	a_ramp_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && ramp_active_q) |-> (ramp_val_q != ramp_tgt_q))
		else $error("idle with an active ramp that has reached its target");

	// the store is never read and written in one cycle
	a_store_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(pos_req.rd_en && pos_req.wr_en))
		else $error("position store read and written together");

	// a refusal carries no pulse width and closes its run
	a_refusal_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_REFUSED) |-> (out_q.pw == '0 && out_q.last))
		else $error("malformed refusal result");

	// the reset sweep runs with the ramp already aborted
	a_sweep_no_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RST) |-> !ramp_active_q)
		else $error("ramp still active during reset sweep");

endmodule

>>> hdl/msrp_alu.sv
module msrp_alu (
	input  msrp_pkg::alu_req_t req,
	output msrp_pkg::alu_rsp_t rsp
);
	import msrp_pkg::*;

	logic signed [ALU_W-1:0] sum;

	// one adder shared by every add, step and compare of the sequencer
	always_comb begin
		unique case (req.op)
			ALU_ADD: sum = req.a + req.b;
			ALU_SUB: sum = req.a - req.b;
			default: sum = req.a + req.b;
		endcase
		rsp.res = sum;
		rsp.lt  = sum[ALU_W-1];
		rsp.eq  = (sum == '0);
	end

endmodule

>>> hdl/msrp_pos_mem.sv
module msrp_pos_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  msrp_pkg::pos_req_t          req,
	output logic [msrp_pkg::POS_W-1:0]  rd_data
);
	import msrp_pkg::*;

	logic [POS_W-1:0] mem_q [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	logic [POS_W-1:0] rd_data_q;

	// entries not yet written read as the reset center count (CENTER_RESET) after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.addr] <= 1'b1;
		end
	end

	// storage write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= valid_q[req.addr] ? mem_q[req.addr] : CENTER_RESET;
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> verif/tb_multi_servo_ramp_positioner.sv
module tb_multi_servo_ramp_positioner;
	timeunit 1ns;
	timeprecision 1ps;

	import msrp_pkg::*;

	localparam int IDLE_MAX     = 12;
	localparam int GUARD_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int REPORT_MAX   = 40;

	logic clk;
	logic arst_n;

	msrp_cmd_if cmd_ch ();
	msrp_res_if res_ch ();
	msrp_cfg_if cfg_ch ();

	multi_servo_ramp_positioner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// register copies
	logic [POS_W-1:0]  lo_lim;
	logic [POS_W-1:0]  hi_lim;
	logic [POS_W-1:0]  center_pw;
	logic [TICK_W-1:0] step_div;

	// servo state copies
	logic [POS_W-1:0]  chan_pw [CHANNELS];
	logic              ramping;
	logic [CH_W-1:0]   ramp_ch;
	logic [POS_W-1:0]  ramp_pw;
	logic [POS_W-1:0]  ramp_goal;
	logic [TICK_W-1:0] tick_cnt;

	// pulse width updates and refusals still to come out
	result_t due_pw [$];

	int  mismatches;
	int  moves_sent;
	int  ticks_sent;
	int  resets_sent;
	int  updates_seen;
	int  refusals_seen;
	int  quiet_cycles;
	int  hold_off;
	bit  steady;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t ns mismatch: %s", $time, msg);
		end
	endtask

	task automatic clear_servo_state();
		lo_lim    = MIN_RESET;
		hi_lim    = MAX_RESET;
		center_pw = CENTER_RESET;
		step_div  = STEP_RESET;
		for (int i = 0; i < CHANNELS; i++) begin
			chan_pw[i] = CENTER_RESET;
		end
		ramping   = 1'b0;
		ramp_ch   = '0;
		ramp_pw   = '0;
		ramp_goal = '0;
		tick_cnt  = '0;
	endtask

	task automatic queue_result(input kind_t k, input logic [CH_W-1:0] c,
			input logic [POS_W-1:0] p, input logic l);
		result_t r;
		r.kind = k;
		r.ch   = c;
		r.pw   = p;
		r.last = l;
		due_pw.push_back(r);
	endtask

	// servo positioner behavior for one accepted command
	task automatic track_servo(input op_t op, input logic [CH_W-1:0] ch,
			input logic signed [DELTA_W-1:0] d);
		int               sum;
		int               lim;
		logic [POS_W-1:0] goal;
		case (op)
			OP_MOVE: begin
				if (int'(ch) < CHANNELS) begin
					if (ramping) begin
						queue_result(KIND_REFUSED, ch, '0, 1'b1);
					end else begin
						sum = int'(chan_pw[ch]) + int'(d);
						if (sum < int'(lo_lim)) begin
							goal = lo_lim;
						end else if (sum > int'(hi_lim)) begin
							goal = hi_lim;
						end else begin
							goal = POS_W'(sum);
						end
						if (goal != chan_pw[ch]) begin
							ramping   = 1'b1;
							ramp_ch   = ch;
							ramp_pw   = chan_pw[ch];
							ramp_goal = goal;
							tick_cnt  = '0;
							queue_result(KIND_UPDATE, ch, chan_pw[ch], 1'b1);
						end
					end
				end
			end
			OP_RESET: begin
				ramping  = 1'b0;
				tick_cnt = '0;
				for (int i = 0; i < CHANNELS; i++) begin
					chan_pw[i] = center_pw;
				end
				for (int i = 0; i < EMIT_COUNT; i++) begin
					queue_result(KIND_UPDATE, CH_W'(i), center_pw, i == EMIT_COUNT - 1);
				end
			end
			OP_TICK: begin
				if (ramping) begin
					// zero divider steps on every tick
					lim = (step_div == 0) ? 1 : int'(step_div);
					tick_cnt = tick_cnt + 1'b1;
					if (int'(tick_cnt) >= lim) begin
						tick_cnt = '0;
						if (ramp_pw < ramp_goal) begin
							ramp_pw = ramp_pw + 1'b1;
						end else if (ramp_pw > ramp_goal) begin
							ramp_pw = ramp_pw - 1'b1;
						end
						if (ramp_pw == ramp_goal) begin
							chan_pw[int'(ramp_ch) % CHANNELS] = ramp_goal;
							ramping = 1'b0;
						end
						queue_result(KIND_UPDATE, ramp_ch, ramp_pw, 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// one command transfer; valid stays up for a back-to-back follower
	task automatic issue_cmd(input op_t op, input logic [CH_W-1:0] ch,
			input logic signed [DELTA_W-1:0] d);
		int gap;
		gap = steady ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.opcode  <= op;
		cmd_ch.channel <= ch;
		cmd_ch.delta   <= d;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1) @(posedge clk);
		track_servo(op, ch, d);
		case (op)
			OP_MOVE:  moves_sent++;
			OP_TICK:  ticks_sent++;
			OP_RESET: resets_sent++;
			default: begin
			end
		endcase
	endtask

	// drain all results, then let any silent command finish
	task automatic quiesce();
		cmd_ch.valid <= 1'b0;
		while (due_pw.size() != 0) @(posedge clk);
		repeat (GUARD_CYCLES) @(posedge clk);
	endtask

	// write all four registers while the block is idle
	task automatic apply_setup(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
			input logic [POS_W-1:0] ctr, input logic [TICK_W-1:0] step);
		logic [CFG_DATA_W-1:0] vals [4];
		cfg_reg_t              idx;
		quiesce();
		// upper bits of the divider write carry noise
		vals = '{lo, hi, ctr, {4'($urandom), step}};
		for (int i = 0; i < 4; i++) begin
			idx = cfg_reg_t'(i);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			cfg_ch.data  <= vals[i];
			@(posedge clk);
			while (cfg_ch.ready !== 1'b1) @(posedge clk);
			case (idx)
				REG_MIN:    lo_lim    = vals[i];
				REG_MAX:    hi_lim    = vals[i];
				REG_CENTER: center_pw = vals[i];
				REG_STEP:   step_div  = vals[i][TICK_W-1:0];
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic signed [DELTA_W-1:0] draw_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return DELTA_W'($urandom_range(0, 12) - 6);
		end else if (r < 85) begin
			return DELTA_W'($urandom_range(0, 128) - 64);
		end
		return DELTA_W'($urandom);
	endfunction

	// mostly moves followed by ticks, some resets and unused opcodes
	task automatic random_item();
		int                         r;
		op_t                        op;
		logic [CH_W-1:0]            ch;
		logic signed [DELTA_W-1:0]  d;
		r  = $urandom_range(0, 99);
		ch = CH_W'($urandom);
		d  = draw_delta();
		if (ramping) begin
			op = (r < 78) ? OP_TICK : (r < 90) ? OP_MOVE : (r < 95) ? OP_RESET : OP_NONE;
		end else begin
			op = (r < 60) ? OP_MOVE : (r < 82) ? OP_TICK : (r < 90) ? OP_RESET : OP_NONE;
		end
		issue_cmd(op, ch, d);
	endtask

	// result side: random stalls, long hold-off on request, checking
	initial begin
		result_t want;
		int      stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, IDLE_MAX);
			if (hold_off > 0) begin
				stall    = hold_off;
				hold_off = 0;
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				do @(posedge clk); while (res_ch.valid !== 1'b1);
				repeat (stall - 1) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (res_ch.valid !== 1'b1) @(posedge clk);
			if (due_pw.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0b ch %0d pw %0d last %0b",
					res_ch.kind, res_ch.out_channel, res_ch.pulse_width, res_ch.last));
			end else begin
				want = due_pw.pop_front();
				if (res_ch.kind !== want.kind || res_ch.out_channel !== want.ch ||
						res_ch.pulse_width !== want.pw || res_ch.last !== want.last) begin
					flag_mismatch($sformatf(
						"got kind %0b ch %0d pw %0d last %0b, want kind %0b ch %0d pw %0d last %0b",
						res_ch.kind, res_ch.out_channel, res_ch.pulse_width, res_ch.last,
						want.kind, want.ch, want.pw, want.last));
				end
				if (want.kind == KIND_REFUSED) begin
					refusals_seen++;
				end else begin
					updates_seen++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_multi_servo_ramp_positioner NOT OK");
			$finish;
		end
	end

	// reset-value registers: ignored items, no change, clamp, refusal, reset
	task automatic test_moves_and_refusal();
		issue_cmd(OP_NONE, 4'hF, 13'h1FFF);
		issue_cmd(OP_TICK, 4'h0, 13'h0000);
		issue_cmd(OP_MOVE, 4'h0, 13'sd0);
		issue_cmd(OP_MOVE, 4'hF, 13'sd4095);
		issue_cmd(OP_MOVE, 4'h3, 13'sh1000);
		issue_cmd(OP_TICK, 4'hA, 13'h0AAA);
		issue_cmd(OP_RESET, 4'h5, 13'h1555);
	endtask

	// narrow window with a zero divider: every tick steps
	task automatic test_stepping_window();
		apply_setup(12'd100, 12'd110, 12'd105, 8'd0);
		issue_cmd(OP_RESET, 4'h0, 13'sd0);
		issue_cmd(OP_MOVE, 4'h5, 13'sh1000);
		repeat (5) issue_cmd(OP_TICK, 4'h5, 13'sd0);
		issue_cmd(OP_TICK, 4'h5, 13'sd0);
		issue_cmd(OP_MOVE, 4'h5, 13'sd3);
		repeat (3) issue_cmd(OP_TICK, 4'h5, 13'sd0);
	endtask

	// minimum above maximum: low sums go to min, high sums to max
	task automatic test_inverted_window();
		apply_setup(12'd200, 12'd150, 12'd199, 8'd1);
		issue_cmd(OP_RESET, 4'h0, 13'sd0);
		issue_cmd(OP_MOVE, 4'h9, -13'sd5);
		issue_cmd(OP_TICK, 4'h9, 13'sd0);
		issue_cmd(OP_MOVE, 4'h9, 13'sd0);
	endtask

	task automatic test_random_phase(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
			input logic [POS_W-1:0] ctr, input logic [TICK_W-1:0] step, input int count,
			input bit no_idle);
		apply_setup(lo, hi, ctr, step);
		steady = no_idle;
		repeat (count) random_item();
		steady = 1'b0;
	endtask

	// receiver holds off while commands keep coming back to back
	task automatic test_backpressure();
		apply_setup(MIN_RESET, MAX_RESET, CENTER_RESET, 8'd1);
		hold_off = HOLD_CYCLES;
		steady   = 1'b1;
		issue_cmd(OP_RESET, 4'h0, 13'sd0);
		repeat (29) random_item();
		steady = 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.opcode  = OP_NONE;
		cmd_ch.channel = '0;
		cmd_ch.delta   = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_MIN;
		cfg_ch.data    = '0;
		mismatches     = 0;
		moves_sent     = 0;
		ticks_sent     = 0;
		resets_sent    = 0;
		updates_seen   = 0;
		refusals_seen  = 0;
		quiet_cycles   = 0;
		hold_off       = 0;
		steady         = 1'b0;
		clear_servo_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_moves_and_refusal();
		test_stepping_window();
		test_inverted_window();
		test_random_phase(12'd0, 12'd40, 12'd0, 8'd1, 80, 1'b0);
		test_random_phase(12'd4000, 12'd4095, 12'd4095, 8'd2, 80, 1'b1);
		test_random_phase(12'd300, 12'd200, 12'd250, 8'd3, 60, 1'b0);
		test_random_phase(MIN_RESET, MAX_RESET, CENTER_RESET, 8'd0, 60, 1'b0);
		test_random_phase(12'd4095, 12'd0, 12'd2048, 8'd255, 30, 1'b0);
		test_backpressure();

		quiesce();
		$display("ran %0d moves, %0d ticks, %0d resets over nine register settings",
			moves_sent, ticks_sent, resets_sent);
		$display("checked %0d pulse width updates and %0d busy refusals",
			updates_seen, refusals_seen);
		if (mismatches == 0) begin
			$display("tb_multi_servo_ramp_positioner OK");
		end else begin
			$display("tb_multi_servo_ramp_positioner NOT OK");
		end
		$finish;
	end

endmodule
